/* sv/ppvc_pkg.sv */
// ----------------------------------------------------------------------------
// ppvc_pkg
// Shared constants, tables and functions for the planar PI velocity controller.
// ----------------------------------------------------------------------------
package ppvc_pkg;

  localparam int FRAC_BITS_DEF  = 16;
  localparam int ANGLE_BITS_DEF = 16;
  localparam int CORDIC_STEPS   = 28;
  localparam int STEP_W         = 5;
  localparam int NUM_AXES       = 3;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;

  localparam logic [3:0] REG_GAIN_NOW  = 4'd0;
  localparam logic [3:0] REG_GAIN_PREV = 4'd4;
  localparam logic [3:0] REG_LIN_LIM   = 4'd8;
  localparam logic [3:0] REG_ANG_LIM   = 4'd12;

  function automatic logic signed [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic signed [31:0] r;
    case (i)
      5'd0: r = 32'sd536870912;
      5'd1: r = 32'sd316933406;
      5'd2: r = 32'sd167458907;
      5'd3: r = 32'sd85004756;
      5'd4: r = 32'sd42667331;
      5'd5: r = 32'sd21354465;
      5'd6: r = 32'sd10680862;
      5'd7: r = 32'sd5340245;
      5'd8: r = 32'sd2670163;
      5'd9: r = 32'sd1335087;
      5'd10: r = 32'sd667544;
      5'd11: r = 32'sd333772;
      5'd12: r = 32'sd166886;
      5'd13: r = 32'sd83443;
      5'd14: r = 32'sd41722;
      5'd15: r = 32'sd20861;
      5'd16: r = 32'sd10430;
      5'd17: r = 32'sd5215;
      5'd18: r = 32'sd2608;
      5'd19: r = 32'sd1304;
      5'd20: r = 32'sd652;
      5'd21: r = 32'sd326;
      5'd22: r = 32'sd163;
      5'd23: r = 32'sd81;
      5'd24: r = 32'sd41;
      5'd25: r = 32'sd20;
      5'd26: r = 32'sd10;
      5'd27: r = 32'sd5;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* sv/ppvc_axis_lane.sv */
// ----------------------------------------------------------------------------
// ppvc_axis_lane
// One PI lane: u = prev_command + round(g0*e) + round(g1*prev_e), saturated.
// Two products are formed in turn through one multiplier.
// ----------------------------------------------------------------------------
module ppvc_axis_lane #(
  parameter int FRAC_BITS = ppvc_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] gain_now,
  input  logic signed [31:0] gain_prev,
  input  logic signed [31:0] err,
  input  logic signed [31:0] prev_err,
  input  logic signed [31:0] prev_cmd,
  output logic signed [31:0] u,
  output logic               done
);

  localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_NOW  = 2'd1;
  localparam logic [1:0] PH_PREV = 2'd2;
  localparam logic [1:0] PH_SUM  = 2'd3;

  logic [1:0]         phase_r, phase_nxt;
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r, acc_nxt;
  logic signed [31:0] u_r, u_nxt;
  logic signed [31:0] ma, mb;
  logic signed [63:0] rnd;

  always_comb begin
    ma = (phase_r == PH_NOW) ? gain_now : gain_prev;
    mb = (phase_r == PH_NOW) ? err : prev_err;
    rnd = (prod_r + HALF) >>> FRAC_BITS;
    phase_nxt = phase_r;
    acc_nxt = acc_r;
    u_nxt = u_r;
    case (phase_r)
      PH_IDLE: begin
        if (start) begin
          phase_nxt = PH_NOW;
          acc_nxt = 64'(prev_cmd);
        end
      end
      PH_NOW: phase_nxt = PH_PREV;
      PH_PREV: begin
        acc_nxt = acc_r + rnd;
        phase_nxt = PH_SUM;
      end
      PH_SUM: begin
        u_nxt = ppvc_pkg::sat32(acc_r + rnd);
        phase_nxt = PH_IDLE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    prod_r <= ma * mb;
    acc_r <= acc_nxt;
    u_r <= u_nxt;
  end

  assign u = u_r;
  assign done = (phase_r == PH_SUM);

endmodule

/* sv/ppvc_cordic.sv */
// ----------------------------------------------------------------------------
// ppvc_cordic
// Iterative CORDIC giving Q30 cosine and sine, one rotation per cycle.
// ----------------------------------------------------------------------------
module ppvc_cordic #(
  parameter int ANGLE_BITS = ppvc_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [15:0]        heading,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30,
  output logic               done
);

  localparam int S = ppvc_pkg::STEP_W;

  logic               busy_r;
  logic [S-1:0]       step_r;
  logic [1:0]         quad_r;
  logic signed [31:0] x_r, y_r, z_r;
  logic signed [31:0] c_r, s_r;
  logic               done_r;
  logic [31:0]        a;
  logic [1:0]         quad;
  logic signed [31:0] dx, dy, xn, yn;

  always_comb begin
    a = 32'(heading) << (32 - ANGLE_BITS);
    quad = 2'((a + 32'h2000_0000) >> 30);
    dx = y_r >>> step_r;
    dy = x_r >>> step_r;
    xn = z_r[31] ? x_r + dx : x_r - dx;
    yn = z_r[31] ? y_r - dy : y_r + dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        if (step_r == S'(ppvc_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r + 1'b1;
      end
    end
    if (start) begin
      quad_r <= quad;
      x_r <= ppvc_pkg::CORDIC_GAIN_Q30;
      y_r <= '0;
      z_r <= $signed(a - {quad, 30'd0});
    end else if (busy_r) begin
      x_r <= xn;
      y_r <= yn;
      z_r <= z_r[31] ? z_r + ppvc_pkg::atan_turn(step_r)
                     : z_r - ppvc_pkg::atan_turn(step_r);
      if (step_r == S'(ppvc_pkg::CORDIC_STEPS - 1)) begin
        case (quad_r)
          2'd0: begin c_r <= xn;  s_r <= yn;  end
          2'd1: begin c_r <= -yn; s_r <= xn;  end
          2'd2: begin c_r <= -xn; s_r <= -yn; end
          default: begin c_r <= yn; s_r <= -xn; end
        endcase
      end
    end
  end

  assign cos_q30 = c_r;
  assign sin_q30 = s_r;
  assign done = done_r;

endmodule

/* sv/ppvc_merge.sv */
// ----------------------------------------------------------------------------
// ppvc_merge
// Rotates the lane results into the robot frame and clamps all three axes.
// ----------------------------------------------------------------------------
module ppvc_merge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] ux,
  input  logic signed [31:0] uy,
  input  logic signed [31:0] uw,
  input  logic signed [31:0] cos_q30,
  input  logic signed [31:0] sin_q30,
  input  logic [30:0]        lin_lim,
  input  logic [30:0]        ang_lim,
  output logic signed [31:0] vx,
  output logic signed [31:0] vy,
  output logic signed [31:0] w,
  output logic [2:0]         flags,
  output logic               done
);

  localparam logic signed [65:0] HALF30 = 66'sd1 <<< 29;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CX   = 3'd1;
  localparam logic [2:0] ST_SY   = 3'd2;
  localparam logic [2:0] ST_VX   = 3'd3;
  localparam logic [2:0] ST_CY   = 3'd4;
  localparam logic [2:0] ST_VY   = 3'd5;
  localparam logic [2:0] ST_W    = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]         ph_r;
  logic signed [63:0] p_r;
  logic signed [65:0] acc_r;
  logic signed [31:0] vx_r, vy_r, w_r;
  logic [2:0]         fl_r;
  logic signed [31:0] ma, mb;
  logic signed [65:0] sum, rv;
  logic signed [33:0] lim, clv;
  logic               clf;

  always_comb begin
    case (ph_r)
      ST_CX: begin ma = cos_q30; mb = ux; end
      ST_SY: begin ma = sin_q30; mb = uy; end
      ST_VX: begin ma = cos_q30; mb = uy; end
      default: begin ma = sin_q30; mb = ux; end
    endcase
    if (ph_r == ST_VY) begin
      sum = acc_r - 66'(p_r);
    end else begin
      sum = acc_r + 66'(p_r);
    end
    rv = (sum + HALF30) >>> 30;
    lim = (ph_r == ST_W) ? 34'(ang_lim) : 34'(lin_lim);
    clf = 1'b0;
    clv = rv[33:0];
    if (ph_r == ST_W) begin
      clv = 34'(uw);
    end
    if (ph_r == ST_W ? (clv > lim) : (rv > 66'(lim))) begin
      clv = lim;
      clf = 1'b1;
    end else if (ph_r == ST_W ? (clv < -lim) : (rv < -66'(lim))) begin
      clv = -lim;
      clf = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= ST_IDLE;
    end else begin
      case (ph_r)
        ST_IDLE: if (start) ph_r <= ST_CX;
        ST_DONE: ph_r <= ST_IDLE;
        default: ph_r <= ph_r + 3'd1;
      endcase
    end
    p_r <= ma * mb;
    case (ph_r)
      ST_IDLE: fl_r <= 3'd0;
      ST_SY: acc_r <= 66'(p_r);
      ST_VX: begin
        vx_r <= clv[31:0];
        fl_r[0] <= clf;
      end
      ST_CY: acc_r <= 66'(p_r);
      ST_VY: begin
        vy_r <= clv[31:0];
        fl_r[1] <= clf;
      end
      ST_W: begin
        w_r <= clv[31:0];
        fl_r[2] <= clf;
      end
      default: ;
    endcase
  end

  assign vx = vx_r;
  assign vy = vy_r;
  assign w = w_r;
  assign flags = fl_r;
  assign done = (ph_r == ST_DONE);

endmodule

/* sv/planar_pi_velocity_controller_top.sv */
// ----------------------------------------------------------------------------
// planar_pi_velocity_controller_top
// Three-axis incremental PI controller with inverse rotation and clamping.
// No new input beat is taken while a beat is in flight; the next one can be taken
// the cycle after the result beat has been accepted.
// Reset (rst_n, synchronous) restores default gains and limits and zeroes
// the stored errors and commands.
// ----------------------------------------------------------------------------
module planar_pi_velocity_controller_top #(
  parameter int FRAC_BITS  = ppvc_pkg::FRAC_BITS_DEF,
  parameter int ANGLE_BITS = ppvc_pkg::ANGLE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_err_x,
  input  logic signed [31:0] in_err_y,
  input  logic signed [31:0] in_err_theta,
  input  logic [15:0]        in_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_cmd_vx,
  output logic signed [31:0] out_cmd_vy,
  output logic signed [31:0] out_cmd_w,
  output logic [2:0]         out_clamp_flags,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int N = ppvc_pkg::NUM_AXES;

  localparam logic signed [63:0] GN_WIDE = 64'sd150 <<< FRAC_BITS;
  localparam logic signed [31:0] GN_RST =
    (GN_WIDE > 64'sd2147483647) ? 32'sh7FFF_FFFF : GN_WIDE[31:0];
  localparam logic signed [63:0] GP_WIDE = -(64'sd50 <<< FRAC_BITS);
  localparam logic signed [31:0] GP_RST = GP_WIDE[31:0];
  localparam logic [63:0] LL_WIDE = ((64'd454 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [30:0] LL_RST = LL_WIDE[30:0];
  localparam logic [63:0] AL_WIDE = ((64'd157 << FRAC_BITS) + 64'd50) / 64'd100;
  localparam logic [30:0] AL_RST = AL_WIDE[30:0];

  logic signed [31:0] gn_r, gp_r;
  logic [30:0]        ll_r, al_r;
  logic signed [31:0] pe_r [N];
  logic signed [31:0] pc_r [N];
  logic signed [31:0] e_r [N];
  logic [15:0]        hd_r;
  logic               busy_r, ovalid_r;
  logic               lane_start_r, cordic_ok_r, lane_ok_r;
  logic signed [31:0] u [N];
  logic [N-1:0]       ldone;
  logic signed [31:0] c_q30, s_q30;
  logic               cdone, mdone;
  logic signed [31:0] vx, vy, w;
  logic [2:0]         fl;
  logic               acc;

  assign pready = 1'b1;
  assign acc = in_valid && in_ready;
  assign in_ready = !busy_r && !ovalid_r;

  always_comb begin
    case (paddr)
      ppvc_pkg::REG_GAIN_NOW:  prdata = gn_r;
      ppvc_pkg::REG_GAIN_PREV: prdata = gp_r;
      ppvc_pkg::REG_LIN_LIM:   prdata = {1'b0, ll_r};
      ppvc_pkg::REG_ANG_LIM:   prdata = {1'b0, al_r};
      default:                 prdata = '0;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_lane
      ppvc_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
        .clk(clk), .rst_n(rst_n), .start(lane_start_r),
        .gain_now(gn_r), .gain_prev(gp_r), .err(e_r[g]),
        .prev_err(pe_r[g]), .prev_cmd(pc_r[g]), .u(u[g]), .done(ldone[g])
      );
    end
  endgenerate

  ppvc_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .start(lane_start_r), .heading(hd_r),
    .cos_q30(c_q30), .sin_q30(s_q30), .done(cdone)
  );

  ppvc_merge u_merge (
    .clk(clk), .rst_n(rst_n), .start(cordic_ok_r && lane_ok_r),
    .ux(u[0]), .uy(u[1]), .uw(u[2]), .cos_q30(c_q30), .sin_q30(s_q30),
    .lin_lim(ll_r), .ang_lim(al_r),
    .vx(vx), .vy(vy), .w(w), .flags(fl), .done(mdone)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gn_r <= GN_RST;
      gp_r <= GP_RST;
      ll_r <= LL_RST;
      al_r <= AL_RST;
      busy_r <= 1'b0;
      ovalid_r <= 1'b0;
      lane_start_r <= 1'b0;
      cordic_ok_r <= 1'b0;
      lane_ok_r <= 1'b0;
      for (int i = 0; i < N; i++) begin
        pe_r[i] <= '0;
        pc_r[i] <= '0;
      end
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr)
          ppvc_pkg::REG_GAIN_NOW:  gn_r <= pwdata;
          ppvc_pkg::REG_GAIN_PREV: gp_r <= pwdata;
          ppvc_pkg::REG_LIN_LIM:   ll_r <= pwdata[30:0];
          ppvc_pkg::REG_ANG_LIM:   al_r <= pwdata[30:0];
          default: ;
        endcase
      end
      lane_start_r <= acc;
      if (acc) begin
        busy_r <= 1'b1;
      end
      if (cdone) cordic_ok_r <= 1'b1;
      if (&ldone) lane_ok_r <= 1'b1;
      if (cordic_ok_r && lane_ok_r) begin
        cordic_ok_r <= 1'b0;
        lane_ok_r <= 1'b0;
      end
      if (mdone) begin
        busy_r <= 1'b0;
        ovalid_r <= 1'b1;
        pc_r[0] <= vx;
        pc_r[1] <= vy;
        pc_r[2] <= w;
        for (int i = 0; i < N; i++) begin
          pe_r[i] <= e_r[i];
        end
      end else if (ovalid_r && out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
    if (acc) begin
      e_r[0] <= in_err_x;
      e_r[1] <= in_err_y;
      e_r[2] <= in_err_theta;
      hd_r <= in_heading;
    end
  end

  assign out_valid = ovalid_r;
  assign out_cmd_vx = pc_r[0];
  assign out_cmd_vy = pc_r[1];
  assign out_cmd_w = pc_r[2];

  logic [2:0] fl_out_r;
  always_ff @(posedge clk) begin
    if (mdone) begin
      fl_out_r <= fl;
    end
  end
  assign out_clamp_flags = fl_out_r;

endmodule

/* sim/tb_planar_pi_velocity_controller_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_planar_pi_velocity_controller_top
// Self-checking bench for the planar PI velocity controller. A table of
// directed beats runs first, then randomized beats under several gain and
// limit settings. Each result beat is checked against a predictor that
// tracks the stored errors and commands.
// ----------------------------------------------------------------------------
module tb_planar_pi_velocity_controller_top;

  localparam int FB = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] w;
    logic [2:0]         flags;
  } cmd_t;

  typedef struct {
    logic signed [31:0] ex;
    logic signed [31:0] ey;
    logic signed [31:0] et;
    logic [15:0]        hd;
    logic               known;
    cmd_t               res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] in_err_x = '0;
  logic signed [31:0] in_err_y = '0;
  logic signed [31:0] in_err_theta = '0;
  logic [15:0] in_heading = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_cmd_vx;
  logic signed [31:0] out_cmd_vy;
  logic signed [31:0] out_cmd_w;
  logic [2:0] out_clamp_flags;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  planar_pi_velocity_controller_top u_top (.*);

  always #2 clk = ~clk;

  logic signed [31:0] k_now, k_prev;
  longint lin_lim, ang_lim;
  logic signed [31:0] last_err [3];
  logic signed [31:0] last_cmd [3];
  cmd_t pending_cmds[$];
  int errors = 0;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;

  localparam longint ATAN [28] = '{536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5};

  function automatic longint sat_word(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint limit_axis(longint v, longint lim, int b,
                                        ref logic [2:0] f);
    if (v > lim) begin
      f[b] = 1'b1;
      return lim;
    end
    if (v < -lim) begin
      f[b] = 1'b1;
      return -lim;
    end
    return v;
  endfunction

  task automatic heading_sincos(input logic [15:0] hd, output longint c,
                                output longint s);
    logic [31:0] a;
    logic [1:0] q;
    longint x, y, z, dx, dy;
    a = {hd, 16'h0};
    q = 2'((a + 32'h2000_0000) >> 30);
    z = longint'($signed(a - {q, 30'h0}));
    x = 652032874;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN[i];
      end else begin
        x += dx; y -= dy; z += ATAN[i];
      end
    end
    case (q)
      2'd0: begin c = x; s = y; end
      2'd1: begin c = -y; s = x; end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endtask

  task automatic predict_command(input row_t r, output cmd_t res);
    longint e [3], u [3], c, s, vx, vy, w;
    logic [2:0] f;
    f = '0;
    e[0] = r.ex; e[1] = r.ey; e[2] = r.et;
    for (int i = 0; i < 3; i++) begin
      u[i] = sat_word(longint'(last_cmd[i])
        + ((longint'(k_now) * e[i] + (64'sd1 << (FB - 1))) >>> FB)
        + ((longint'(k_prev) * longint'(last_err[i]) + (64'sd1 << (FB - 1))) >>> FB));
    end
    heading_sincos(r.hd, c, s);
    vx = (c * u[0] + s * u[1] + (64'sd1 << 29)) >>> 30;
    vy = (c * u[1] - s * u[0] + (64'sd1 << 29)) >>> 30;
    vx = limit_axis(vx, lin_lim, 0, f);
    vy = limit_axis(vy, lin_lim, 1, f);
    w = limit_axis(u[2], ang_lim, 2, f);
    res.vx = 32'(vx); res.vy = 32'(vy); res.w = 32'(w); res.flags = f;
    last_cmd[0] = res.vx; last_cmd[1] = res.vy; last_cmd[2] = res.w;
    for (int i = 0; i < 3; i++) last_err[i] = 32'(e[i]);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    case (addr)
      ppvc_pkg::REG_GAIN_NOW: k_now = data;
      ppvc_pkg::REG_GAIN_PREV: k_prev = data;
      ppvc_pkg::REG_LIN_LIM: lin_lim = longint'(data[30:0]);
      ppvc_pkg::REG_ANG_LIM: ang_lim = longint'(data[30:0]);
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic send_beat(input row_t r);
    cmd_t res;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    predict_command(r, res);
    if (r.known && res != r.res) begin
      $error("table row: expected vx %0d vy %0d w %0d f %0d got vx %0d vy %0d w %0d f %0d",
             r.res.vx, r.res.vy, r.res.w, r.res.flags, res.vx, res.vy, res.w, res.flags);
      errors++;
    end
    pending_cmds.push_back(res);
    in_valid <= 1'b1;
    in_err_x <= r.ex; in_err_y <= r.ey; in_err_theta <= r.et; in_heading <= r.hd;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFC | $urandom_range(0, 3);
      2: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic row_t mk(logic [31:0] ex, logic [31:0] ey, logic [31:0] et,
                              logic [15:0] hd);
    row_t r;
    r.ex = ex; r.ey = ey; r.et = et; r.hd = hd; r.known = 1'b0;
    r.res = '{0, 0, 0, 0};
    return r;
  endfunction

  initial begin
    row_t tbl[$];
    row_t r;
    k_now = 32'sd9830400; k_prev = -32'sd3276800; lin_lim = 297533; ang_lim = 102892;
    for (int i = 0; i < 3; i++) begin
      last_err[i] = '0; last_cmd[i] = '0;
    end
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Zero error after reset gives zero commands and no clamping.
    r = mk(0, 0, 0, 0); r.known = 1'b1; tbl.push_back(r);
    // Large errors at the extremes saturate, then clamp to the default limits.
    r = mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h0); r.known = 1'b1;
    r.res = '{32'sd297533, 32'sd297533, 32'sd102892, 3'b111}; tbl.push_back(r);
    r = mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0); r.known = 1'b1;
    r.res = '{-32'sd297533, -32'sd297533, -32'sd102892, 3'b111}; tbl.push_back(r);
    tbl.push_back(mk(32'h0001_0000, 0, 0, 16'h4000));
    tbl.push_back(mk(0, 32'h0001_0000, 0, 16'h8000));
    tbl.push_back(mk(32'hFFFF_0000, 32'h0000_8000, 32'h0000_0100, 16'hC000));
    tbl.push_back(mk(32'h0000_0100, 32'hFFFF_FF00, 32'hFFFF_0000, 16'h2000));
    tbl.push_back(mk(32'h0000_1000, 32'h0000_1000, 0, 16'hE000));
    tbl.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 16'hFFFF));
    tbl.push_back(mk(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555));
    tbl.push_back(mk(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 16'hAAAA));
    tbl.push_back(mk(0, 0, 0, 16'h1FFF));
    foreach (tbl[i]) send_beat(tbl[i]);
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          write_reg(ppvc_pkg::REG_LIN_LIM, 32'h0); write_reg(ppvc_pkg::REG_ANG_LIM, 32'h0);
        end
        1: begin
          write_reg(ppvc_pkg::REG_GAIN_NOW, 32'h7FFF_FFFF);
          write_reg(ppvc_pkg::REG_GAIN_PREV, 32'h8000_0000);
          write_reg(ppvc_pkg::REG_LIN_LIM, 32'h7FFF_FFFF);
          write_reg(ppvc_pkg::REG_ANG_LIM, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(ppvc_pkg::REG_GAIN_NOW, 32'h8000_0000);
          write_reg(ppvc_pkg::REG_GAIN_PREV, 32'h7FFF_FFFF);
        end
        default: begin
          write_reg(ppvc_pkg::REG_GAIN_NOW, $urandom_range(0, 1) ? rand_word()
                    : 32'($signed($urandom_range(0, 1 << 24)) - (1 << 23)));
          write_reg(ppvc_pkg::REG_GAIN_PREV, $urandom_range(0, 1) ? rand_word()
                    : 32'($signed($urandom_range(0, 1 << 23)) - (1 << 22)));
          write_reg(ppvc_pkg::REG_LIN_LIM, $urandom_range(0, 2) == 0 ? $urandom
                    : $urandom_range(1, 1 << 22));
          write_reg(ppvc_pkg::REG_ANG_LIM, $urandom_range(0, 2) == 0 ? $urandom
                    : $urandom_range(1, 1 << 22));
        end
      endcase
      if (ph == 6) calm = 1'b1;
      for (int n = 0; n < 250; n++) begin
        if (n == 120) drain_results();
        if ($urandom_range(0, 1))
          r = mk(rand_word(), rand_word(), rand_word(), 16'($urandom));
        else
          r = mk(32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17)),
                 16'($urandom));
        send_beat(r);
      end
      drain_results();
    end

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cmd_t want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_valid && out_ready) begin
      if (pending_cmds.size() == 0) begin
        $error("result beat with no expected result");
        errors++;
      end else begin
        want = pending_cmds.pop_front();
        if (out_cmd_vx !== want.vx) begin
          $error("cmd_vx expected %0d actual %0d", want.vx, out_cmd_vx);
          errors++;
        end
        if (out_cmd_vy !== want.vy) begin
          $error("cmd_vy expected %0d actual %0d", want.vy, out_cmd_vy);
          errors++;
        end
        if (out_cmd_w !== want.w) begin
          $error("cmd_w expected %0d actual %0d", want.w, out_cmd_w);
          errors++;
        end
        if (out_clamp_flags !== want.flags) begin
          $error("clamp_flags expected %0d actual %0d", want.flags, out_clamp_flags);
          errors++;
        end
      end
    end
  end
endmodule
